// ===== hw/rtl/glr_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package glr_pkg;

    // grid limits
    localparam int unsigned MAX_GAP_LINES  = 10;
    localparam int unsigned MAX_FRONT_FILL = 10;

    // the count from the divider saturates here
    localparam int unsigned DIV_CAP = (MAX_GAP_LINES + 1 > MAX_FRONT_FILL) ?
                                      MAX_GAP_LINES + 1 : MAX_FRONT_FILL;
    localparam int unsigned CNT_W   = $clog2(DIV_CAP + 2);

    // field widths
    localparam int unsigned POS_W      = 14;
    localparam int unsigned GRID_W     = 15;
    localparam int unsigned SPC_W      = 10;
    localparam int unsigned GAP_W      = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH   = 2'd0,
        CFG_FRAME_EXTENT = 2'd1,
        CFG_LINE_SPACING = 2'd2
    } cfg_idx_t;

    // which gap goes into the divider
    typedef enum logic [1:0] {
        DIV_END   = 2'd0,
        DIV_FRONT = 2'd1,
        DIV_GAP   = 2'd2
    } div_src_t;

    // start position of a run of grid lines
    typedef enum logic [1:0] {
        RUN_POS  = 2'd0,
        RUN_PEND = 2'd1,
        RUN_LAST = 2'd2
    } run_src_t;

    // length of a run of grid lines
    typedef enum logic [1:0] {
        CNT_ONE   = 2'd0,
        CNT_FRONT = 2'd1,
        CNT_GAP   = 2'd2,
        CNT_END   = 2'd3
    } cnt_src_t;

    // what goes into the output register
    typedef enum logic [1:0] {
        EMIT_RUN   = 2'd0,
        EMIT_PEND  = 2'd1,
        EMIT_EMPTY = 2'd2
    } emit_src_t;

    // controller to datapath
    typedef struct packed {
        logic      latch;
        logic      div_load;
        div_src_t  div_src;
        logic      div_step;
        logic      end_save;
        logic      run_load;
        run_src_t  run_src;
        cnt_src_t  cnt_src;
        logic      back_step;
        logic      run_step;
        logic      emit;
        emit_src_t emit_src;
        logic      emit_end;
        logic      commit;
        logic      clear;
    } glr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fin;
        logic qa_zero;
        logic qa_three;
        logic end_big;
        logic main_front;
        logic main_judge;
        logic main_big;
        logic keep_one;
        logic div_done;
        logic div_fit;
        logic back_zero;
        logic run_last;
        logic end_ok;
        logic out_free;
    } glr_status_t;

endpackage

// ===== hw/rtl/glr_ctrl.sv =====
// sequencing state machine of the grid line regularizer
module glr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  glr_pkg::glr_status_t st,
    output glr_pkg::glr_cmd_t    cmd
);
    import glr_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_LOAD  = 14'b00000000000010,
        ST_EDIV  = 14'b00000000000100,
        ST_MAIN  = 14'b00000000001000,
        ST_FDIV  = 14'b00000000010000,
        ST_GDIV  = 14'b00000000100000,
        ST_FBACK = 14'b00000001000000,
        ST_MRUN  = 14'b00000010000000,
        ST_POST  = 14'b00000100000000,
        ST_PEND  = 14'b00001000000000,
        ST_ESET  = 14'b00010000000000,
        ST_ERUN  = 14'b00100000000000,
        ST_EMPTY = 14'b01000000000000,
        ST_CLEAR = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (st.fin && st.qa_zero) begin
                    state_next = ST_EMPTY;
                end else if (st.fin && st.end_big) begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = DIV_END;
                    state_next   = ST_EDIV;
                end else begin
                    state_next = ST_MAIN;
                end
            end
            ST_EDIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    cmd.end_save = 1'b1;
                    state_next   = ST_MAIN;
                end
            end
            ST_MAIN: begin
                priority if (st.main_front) begin
                    if (st.main_big) begin
                        cmd.div_load = 1'b1;
                        cmd.div_src  = DIV_FRONT;
                        state_next   = ST_FDIV;
                    end else begin
                        cmd.run_load = 1'b1;
                        cmd.run_src  = RUN_POS;
                        cmd.cnt_src  = CNT_ONE;
                        state_next   = ST_MRUN;
                    end
                end else if (st.main_judge) begin
                    if (st.main_big) begin
                        cmd.div_load = 1'b1;
                        cmd.div_src  = DIV_GAP;
                        state_next   = ST_GDIV;
                    end else if (st.keep_one) begin
                        cmd.run_load = 1'b1;
                        cmd.run_src  = RUN_PEND;
                        cmd.cnt_src  = CNT_ONE;
                        state_next   = ST_MRUN;
                    end else begin
                        state_next = ST_POST;
                    end
                end else begin
                    state_next = ST_POST;
                end
            end
            ST_FDIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    cmd.run_load = 1'b1;
                    cmd.run_src  = RUN_POS;
                    cmd.cnt_src  = CNT_FRONT;
                    state_next   = ST_FBACK;
                end
            end
            ST_GDIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    if (st.div_fit) begin
                        cmd.run_load = 1'b1;
                        cmd.run_src  = RUN_PEND;
                        cmd.cnt_src  = CNT_GAP;
                        state_next   = ST_MRUN;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_FBACK: begin
                if (st.back_zero) begin
                    state_next = ST_MRUN;
                end else begin
                    cmd.back_step = 1'b1;
                end
            end
            ST_MRUN: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_RUN;
                    cmd.emit_end = st.fin && st.run_last && !st.qa_three && !st.end_ok;
                    cmd.run_step = 1'b1;
                    if (st.run_last) begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_POST: begin
                cmd.commit = 1'b1;
                priority if (!st.fin) begin
                    state_next = ST_IDLE;
                end else if (st.qa_three) begin
                    state_next = ST_PEND;
                end else if (st.end_ok) begin
                    state_next = ST_ESET;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_PEND: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_PEND;
                    cmd.emit_end = !st.end_ok;
                    state_next   = st.end_ok ? ST_ESET : ST_CLEAR;
                end
            end
            ST_ESET: begin
                cmd.run_load = 1'b1;
                cmd.run_src  = RUN_LAST;
                cmd.cnt_src  = CNT_END;
                state_next   = ST_ERUN;
            end
            ST_ERUN: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_RUN;
                    cmd.emit_end = st.run_last;
                    cmd.run_step = 1'b1;
                    if (st.run_last) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_EMPTY: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_EMPTY;
                    cmd.emit_end = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/glr_dpath.sv =====
// datapath: config, frame state, gap divider, run generator, output register
module glr_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [glr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [glr_pkg::POS_W-1:0]        s_line_position,
    input  logic [glr_pkg::POS_W-1:0]        s_line_length,
    input  logic                             s_final_line,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [glr_pkg::GRID_W-1:0]       m_grid_position,
    output logic                             m_list_end,
    output logic                             m_list_empty,
    input  glr_pkg::glr_cmd_t                cmd,
    output glr_pkg::glr_status_t             st
);
    import glr_pkg::*;

    typedef logic signed [GAP_W-1:0] gap_t;

    // configuration
    logic [POS_W-1:0] min_length_reg, frame_extent_reg;
    logic [SPC_W-1:0] line_spacing_reg;

    // frame state
    logic [1:0]        q_reg, q_next;
    logic [POS_W-1:0]  pend_reg, pend_next;
    logic [GRID_W-1:0] last_reg, last_next;

    // latched item
    logic [POS_W-1:0] pos_reg;
    logic             qual_reg, fin_reg;

    // divider
    logic [GAP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // end fill result
    logic             end_ok_reg, end_ok_next;
    logic [CNT_W-1:0] end_n_reg, end_n_next;

    // run generator
    logic [GRID_W-1:0] run_pos_reg, run_pos_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [CNT_W-1:0]  back_reg, back_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [GRID_W-1:0] out_pos_reg, out_pos_next;
    logic              out_end_reg, out_end_next;
    logic              out_empty_reg, out_empty_next;

    logic [SPC_W-1:0]   spc;
    logic [SPC_W+1:0]   three_s;
    gap_t               small_th, big_th, half_s;
    logic [1:0]         qa;
    logic [GRID_W-1:0]  end_base;
    gap_t               end_gap, front_gap, right_gap, left_gap, div_in;
    logic [CNT_W-1:0]   front_n;

    // spacing and thresholds, zero spacing acts as one
    always_comb begin
        spc      = (line_spacing_reg == '0) ? SPC_W'(1) : line_spacing_reg;
        three_s  = {1'b0, spc, 1'b0} + {2'b00, spc};
        small_th = gap_t'(three_s >> 2);
        big_th   = gap_t'(three_s >> 1);
        half_s   = gap_t'(spc >> 1);
    end

    // count after this item and the position the end fill starts from
    always_comb begin
        if (!qual_reg) begin
            qa = q_reg;
        end else if (q_reg == 2'd0) begin
            qa = 2'd1;
        end else if (q_reg == 2'd1) begin
            qa = 2'd2;
        end else begin
            qa = 2'd3;
        end
        priority if (qa == 2'd3) begin
            end_base = qual_reg ? {1'b0, pos_reg} : {1'b0, pend_reg};
        end else if (qual_reg && q_reg == 2'd0) begin
            end_base = {1'b0, pos_reg};
        end else begin
            end_base = last_reg;
        end
    end

    // gaps
    always_comb begin
        end_gap   = gap_t'({3'b000, frame_extent_reg}) - gap_t'({2'b00, end_base});
        front_gap = gap_t'({3'b000, pos_reg});
        right_gap = gap_t'({3'b000, pos_reg}) - gap_t'({3'b000, pend_reg});
        left_gap  = gap_t'({3'b000, pend_reg}) - gap_t'({2'b00, last_reg});
        unique case (cmd.div_src)
            DIV_END:   div_in = end_gap;
            DIV_FRONT: div_in = front_gap;
            DIV_GAP:   div_in = right_gap;
            default:   div_in = right_gap;
        endcase
        front_n = (cnt_reg > CNT_W'(MAX_FRONT_FILL)) ? CNT_W'(MAX_FRONT_FILL) : cnt_reg;
    end

    // status to the controller
    always_comb begin
        st.fin        = fin_reg;
        st.qa_zero    = (qa == 2'd0);
        st.qa_three   = (qa == 2'd3);
        st.end_big    = (end_gap >= big_th);
        st.main_front = qual_reg && (q_reg == 2'd0);
        st.main_judge = qual_reg && (q_reg[1] == 1'b1);
        st.main_big   = (q_reg == 2'd0) ? (front_gap >= big_th) : (right_gap >= big_th);
        st.keep_one   = !((left_gap <= small_th) && (right_gap <= small_th));
        st.div_done   = (rem_reg < {{(GAP_W-SPC_W){1'b0}}, spc}) ||
                        (cnt_reg == CNT_W'(DIV_CAP));
        st.div_fit    = (cnt_reg <= CNT_W'(MAX_GAP_LINES));
        st.back_zero  = (back_reg == '0);
        st.run_last   = (run_cnt_reg == CNT_W'(1));
        st.end_ok     = end_ok_reg;
        st.out_free   = !out_valid_reg || m_ready;
    end

    // next values of the working registers
    always_comb begin
        q_next         = q_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        end_ok_next    = end_ok_reg;
        end_n_next     = end_n_reg;
        run_pos_next   = run_pos_reg;
        run_cnt_next   = run_cnt_reg;
        back_next      = back_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_pos_next   = out_pos_reg;
        out_end_next   = out_end_reg;
        out_empty_next = out_empty_reg;

        if (cmd.latch) begin
            end_ok_next = 1'b0;
        end
        // divider: rounded quotient by repeated subtraction
        if (cmd.div_load) begin
            rem_next = GAP_W'(div_in + half_s);
            cnt_next = '0;
        end else if (cmd.div_step && !st.div_done) begin
            rem_next = rem_reg - {{(GAP_W-SPC_W){1'b0}}, spc};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.end_save) begin
            end_ok_next = st.div_fit;
            end_n_next  = cnt_reg;
        end
        // run generator
        if (cmd.run_load) begin
            unique case (cmd.run_src)
                RUN_POS:  run_pos_next = {1'b0, pos_reg};
                RUN_PEND: run_pos_next = {1'b0, pend_reg};
                RUN_LAST: run_pos_next = last_reg;
                default:  run_pos_next = last_reg;
            endcase
            unique case (cmd.cnt_src)
                CNT_ONE:   run_cnt_next = CNT_W'(1);
                CNT_FRONT: run_cnt_next = front_n;
                CNT_GAP:   run_cnt_next = cnt_reg + CNT_W'(1);
                CNT_END:   run_cnt_next = end_n_reg + CNT_W'(1);
                default:   run_cnt_next = CNT_W'(1);
            endcase
            back_next = front_n - CNT_W'(1);
        end else if (cmd.back_step) begin
            run_pos_next = run_pos_reg - {{(GRID_W-SPC_W){1'b0}}, spc};
            back_next    = back_reg - CNT_W'(1);
        end else if (cmd.run_step) begin
            run_pos_next = run_pos_reg + {{(GRID_W-SPC_W){1'b0}}, spc};
            run_cnt_next = run_cnt_reg - CNT_W'(1);
        end
        // result item into the output register
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_end_next   = cmd.emit_end;
            out_empty_next = (cmd.emit_src == EMIT_EMPTY);
            unique case (cmd.emit_src)
                EMIT_RUN:   out_pos_next = run_pos_reg;
                EMIT_PEND:  out_pos_next = {1'b0, pend_reg};
                EMIT_EMPTY: out_pos_next = '0;
                default:    out_pos_next = '0;
            endcase
            if (cmd.emit_src != EMIT_EMPTY) begin
                last_next = out_pos_next;
            end
        end
        // frame state update
        if (cmd.commit) begin
            q_next = qa;
            if (qual_reg && q_reg != 2'd0) begin
                pend_next = pos_reg;
            end
        end
        if (cmd.clear) begin
            q_next    = '0;
            pend_next = '0;
            last_next = '0;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg   <= '0;
            frame_extent_reg <= POS_W'(1024);
            line_spacing_reg <= SPC_W'(32);
            q_reg            <= '0;
            pend_reg         <= '0;
            last_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MIN_LENGTH:   min_length_reg   <= cfg_wr_data;
                    CFG_FRAME_EXTENT: frame_extent_reg <= cfg_wr_data;
                    CFG_LINE_SPACING: line_spacing_reg <= cfg_wr_data[SPC_W-1:0];
                    default: ;
                endcase
            end
            q_reg         <= q_next;
            pend_reg      <= pend_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            pos_reg  <= s_line_position;
            qual_reg <= (s_line_length > min_length_reg);
            fin_reg  <= s_final_line;
        end
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        end_ok_reg    <= end_ok_next;
        end_n_reg     <= end_n_next;
        run_pos_reg   <= run_pos_next;
        run_cnt_reg   <= run_cnt_next;
        back_reg      <= back_next;
        out_pos_reg   <= out_pos_next;
        out_end_reg   <= out_end_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_grid_position = out_pos_reg;
    assign m_list_end      = out_end_reg;
    assign m_list_empty    = out_empty_reg;

endmodule

// ===== hw/rtl/grid_line_regularizer.sv =====
// top level of the grid line regularizer
//
// Input channel s_*: one detected line per item (position, length, final flag),
// positions ascending within a frame. Result channel m_*: grid positions in
// order; list_end marks the last result of a frame, list_empty the single
// zero result of a frame in which no line was longer than min_length.
// The user must write registers through cfg_wr_en/cfg_index/cfg_wr_data while idle; the block does not enforce it.
//
// One item is worked on at a time. An item is latched and judged, then
// runs each rounded gap/spacing division it needs (repeated subtraction,
// one step a cycle, with the count saturating at 11), steps back for the
// front fill if needed and emits its results one by one.
// A final item may run the divider twice (front fill or gap, and end
// fill), at most 23 results per item. s_ready is high only between items.
//
// Reset clears the frame state, loads the default registers and empties the
// output register. When the receiver stalls, the held result stays in the
// output register and the sequencer waits before producing the next one.
module grid_line_regularizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [glr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [glr_pkg::POS_W-1:0]         s_line_position,
    input  logic [glr_pkg::POS_W-1:0]         s_line_length,
    input  logic                              s_final_line,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [glr_pkg::GRID_W-1:0]        m_grid_position,
    output logic                              m_list_end,
    output logic                              m_list_empty
);
    import glr_pkg::*;

    glr_cmd_t    cmd;
    glr_status_t st;

    // sequencer
    glr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath
    glr_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_line_position (s_line_position),
        .s_line_length   (s_line_length),
        .s_final_line    (s_final_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_grid_position (m_grid_position),
        .m_list_end      (m_list_end),
        .m_list_empty    (m_list_empty),
        .cmd             (cmd),
        .st              (st)
    );

    // an empty marker is a zero position that closes the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_list_empty) |-> (m_list_end && m_grid_position == '0))
        else $error("empty marker malformed");

    // after an item is taken the block is not ready in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
